@@ design/radix_number_literal_scanner_core_defines.svh @@
// Assertion macros shared by the scanner RTL.
// Needs nothing; included by files that carry concurrent checks.
`ifndef RADIX_NUMBER_LITERAL_SCANNER_CORE_DEFINES_SVH
`define RADIX_NUMBER_LITERAL_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RNLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner check failed");
`define RNLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner check failed");
`else
`define RNLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RNLS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/rnls_pkg.sv @@
// Package for the radix number literal scanner: widths, mode and radix codes,
// character constants. No dependencies.
`timescale 1ns / 1ps

package rnls_pkg;

    localparam int TEXT_W  = 8;
    localparam int VALUE_W = 64;
    localparam int RADIX_W = 2;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_ZERO = 3'd1,
        MODE_DEC  = 3'd2,
        MODE_BIN  = 3'd3,
        MODE_OCT  = 3'd4,
        MODE_HEX  = 3'd5
    } mode_t;

    typedef enum logic [RADIX_W-1:0] {
        RADIX_DEC = 2'd0,
        RADIX_BIN = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    localparam logic [TEXT_W-1:0] CH_0     = 8'h30;
    localparam logic [TEXT_W-1:0] CH_1     = 8'h31;
    localparam logic [TEXT_W-1:0] CH_7     = 8'h37;
    localparam logic [TEXT_W-1:0] CH_9     = 8'h39;
    localparam logic [TEXT_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [TEXT_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [TEXT_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [TEXT_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [TEXT_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [TEXT_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [TEXT_W-1:0] CH_LO_O  = 8'h6F;
    localparam logic [TEXT_W-1:0] CH_UP_O  = 8'h4F;
    localparam logic [TEXT_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [TEXT_W-1:0] CH_UP_X  = 8'h58;

    // letter digits: low nibble of 'a'/'A' is 1, so add 9
    localparam logic [3:0] HEX_LETTER_BIAS = 4'd9;

endpackage

@@ design/rnls_if.sv @@
// Handshake channels of the scanner: text bytes in, literals out.
// Depends on rnls_pkg.
`timescale 1ns / 1ps

interface rnls_text_if;
    logic                           valid;
    logic                           ready;
    logic [rnls_pkg::TEXT_W-1:0]    text_byte;
    logic                           end_mark;

    modport source (output valid, output text_byte, output end_mark, input ready);
    modport sink   (input valid, input text_byte, input end_mark, output ready);
endinterface

interface rnls_lit_if;
    logic                           valid;
    logic                           ready;
    logic [rnls_pkg::VALUE_W-1:0]   literal_value;
    logic [rnls_pkg::RADIX_W-1:0]   literal_radix;

    modport source (output valid, output literal_value, output literal_radix, input ready);
    modport sink   (input valid, input literal_value, input literal_radix, output ready);
endinterface

@@ design/radix_number_literal_scanner_core.sv @@
// Channel   | Dir | Payload                       | Beat
// text_in   | in  | text_byte[7:0], end_mark      | one source byte or end of text
// lit_out   | out | literal_value[63:0], radix[1:0] | one closed literal
//
// One byte per cycle while the result is not held; beats go via byte register to result register.
// Byte register feeds one step of scan logic (x10 add or shift) into the accumulator register.
// rst_n clears mode, accumulator and both valid flags at once.
// A held result stalls the byte register, mode and accumulator; a new beat is taken if the byte register is empty.
// Depends on rnls_pkg, rnls_if and the defines header.
`timescale 1ns / 1ps
`include "radix_number_literal_scanner_core_defines.svh"

module radix_number_literal_scanner_core (
    input  logic            clk,
    input  logic            rst_n,
    rnls_text_if.sink       text_in,
    rnls_lit_if.source      lit_out
);

    logic                              byte_valid_reg;
    logic [rnls_pkg::TEXT_W-1:0]       byte_reg;
    logic                              end_reg;

    rnls_pkg::mode_t                   mode_reg;
    rnls_pkg::mode_t                   mode_next;
    logic [rnls_pkg::VALUE_W-1:0]      acc_reg;
    logic [rnls_pkg::VALUE_W-1:0]      acc_next;

    logic                              out_valid_reg;
    logic [rnls_pkg::VALUE_W-1:0]      out_value_reg;
    rnls_pkg::radix_t                  out_radix_reg;

    logic                              out_free;
    logic                              advance;
    logic                              emit;
    logic [rnls_pkg::VALUE_W-1:0]      emit_value;
    rnls_pkg::radix_t                  emit_radix;

    logic                              is_dec;
    logic                              is_bin;
    logic                              is_oct;
    logic                              is_hex;
    logic                              is_digit;
    logic                              is_prefix;
    logic [3:0]                        hex_val;
    logic [rnls_pkg::VALUE_W-1:0]      acc_ext;
    rnls_pkg::mode_t                   start_mode;
    logic [rnls_pkg::VALUE_W-1:0]      start_acc;

    assign out_free     = !out_valid_reg || lit_out.ready;
    assign advance      = byte_valid_reg && out_free;
    assign text_in.ready = !byte_valid_reg || out_free;

    assign lit_out.valid         = out_valid_reg;
    assign lit_out.literal_value = out_value_reg;
    assign lit_out.literal_radix = out_radix_reg;

    // character classes
    always_comb
    begin
        is_dec    = byte_reg inside {[rnls_pkg::CH_0:rnls_pkg::CH_9]};
        is_bin    = byte_reg inside {rnls_pkg::CH_0, rnls_pkg::CH_1};
        is_oct    = byte_reg inside {[rnls_pkg::CH_0:rnls_pkg::CH_7]};
        is_hex    = is_dec
                    || (byte_reg inside {[rnls_pkg::CH_LO_A:rnls_pkg::CH_LO_F]})
                    || (byte_reg inside {[rnls_pkg::CH_UP_A:rnls_pkg::CH_UP_F]});
        is_prefix = byte_reg inside {rnls_pkg::CH_LO_B, rnls_pkg::CH_UP_B,
                                     rnls_pkg::CH_LO_O, rnls_pkg::CH_UP_O,
                                     rnls_pkg::CH_LO_X, rnls_pkg::CH_UP_X};
        hex_val   = is_dec ? byte_reg[3:0] : byte_reg[3:0] + rnls_pkg::HEX_LETTER_BIAS;
    end

    always_comb
    begin
        if (byte_reg == rnls_pkg::CH_0)
        begin
            start_mode = rnls_pkg::MODE_ZERO;
            start_acc  = '0;
        end
        else if (is_dec)
        begin
            start_mode = rnls_pkg::MODE_DEC;
            start_acc  = {{(rnls_pkg::VALUE_W-4){1'b0}}, byte_reg[3:0]};
        end
        else
        begin
            start_mode = rnls_pkg::MODE_IDLE;
            start_acc  = '0;
        end
    end

    // digit test and accumulate for the open literal
    always_comb
    begin
        case (mode_reg)
            rnls_pkg::MODE_DEC:
            begin
                is_digit = is_dec;
                acc_ext  = (acc_reg << 3) + (acc_reg << 1)
                           + {{(rnls_pkg::VALUE_W-4){1'b0}}, byte_reg[3:0]};
            end
            rnls_pkg::MODE_BIN:
            begin
                is_digit = is_bin;
                acc_ext  = {acc_reg[rnls_pkg::VALUE_W-2:0], byte_reg[0]};
            end
            rnls_pkg::MODE_OCT:
            begin
                is_digit = is_oct;
                acc_ext  = {acc_reg[rnls_pkg::VALUE_W-4:0], byte_reg[2:0]};
            end
            rnls_pkg::MODE_HEX:
            begin
                is_digit = is_hex;
                acc_ext  = {acc_reg[rnls_pkg::VALUE_W-5:0], hex_val};
            end
            default:
            begin
                is_digit = 1'b0;
                acc_ext  = acc_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        mode_next = start_mode;
        acc_next  = start_acc;
        if (end_reg)
        begin
            mode_next = rnls_pkg::MODE_IDLE;
            acc_next  = '0;
        end
        else
        begin
            case (mode_reg)
                rnls_pkg::MODE_ZERO:
                begin
                    if (byte_reg inside {rnls_pkg::CH_LO_B, rnls_pkg::CH_UP_B})
                    begin
                        mode_next = rnls_pkg::MODE_BIN;
                        acc_next  = '0;
                    end
                    else if (byte_reg inside {rnls_pkg::CH_LO_O, rnls_pkg::CH_UP_O})
                    begin
                        mode_next = rnls_pkg::MODE_OCT;
                        acc_next  = '0;
                    end
                    else if (byte_reg inside {rnls_pkg::CH_LO_X, rnls_pkg::CH_UP_X})
                    begin
                        mode_next = rnls_pkg::MODE_HEX;
                        acc_next  = '0;
                    end
                end
                rnls_pkg::MODE_DEC, rnls_pkg::MODE_BIN,
                rnls_pkg::MODE_OCT, rnls_pkg::MODE_HEX:
                begin
                    if (is_digit)
                    begin
                        mode_next = mode_reg;
                        acc_next  = acc_ext;
                    end
                end
                default:
                begin
                    mode_next = start_mode;
                    acc_next  = start_acc;
                end
            endcase
        end
    end

    // result of this beat
    always_comb
    begin
        case (mode_reg)
            rnls_pkg::MODE_BIN: emit_radix = rnls_pkg::RADIX_BIN;
            rnls_pkg::MODE_OCT: emit_radix = rnls_pkg::RADIX_OCT;
            rnls_pkg::MODE_HEX: emit_radix = rnls_pkg::RADIX_HEX;
            default:            emit_radix = rnls_pkg::RADIX_DEC;
        endcase
        emit_value = (mode_reg == rnls_pkg::MODE_ZERO) ? '0 : acc_reg;
        case (mode_reg)
            rnls_pkg::MODE_ZERO:
                emit = end_reg || !is_prefix;
            rnls_pkg::MODE_DEC, rnls_pkg::MODE_BIN,
            rnls_pkg::MODE_OCT, rnls_pkg::MODE_HEX:
                emit = end_reg || !is_digit;
            default:
                emit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            mode_reg       <= rnls_pkg::MODE_IDLE;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (text_in.ready)
            begin
                byte_valid_reg <= text_in.valid;
            end
            if (advance)
            begin
                mode_reg <= mode_next;
                acc_reg  <= acc_next;
            end
            if (advance && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (lit_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.valid && text_in.ready)
        begin
            byte_reg <= text_in.text_byte;
            end_reg  <= text_in.end_mark;
        end
        if (advance && emit)
        begin
            out_value_reg <= emit_value;
            out_radix_reg <= emit_radix;
        end
    end

    `RNLS_ASSERT_IMPLIES(a_zero_acc_clear, clk, rst_n, mode_reg == rnls_pkg::MODE_ZERO, acc_reg == '0)
    `RNLS_ASSERT_IMPLIES(a_idle_acc_clear, clk, rst_n, mode_reg == rnls_pkg::MODE_IDLE, acc_reg == '0)
    `RNLS_ASSERT_NEXT(a_emit_lands, clk, rst_n, advance && emit, out_valid_reg)
    `RNLS_ASSERT_NEXT(a_byte_kept, clk, rst_n, byte_valid_reg && !out_free, byte_valid_reg && $stable(byte_reg))

endmodule

@@ tb/sv/radix_number_literal_scanner_core_tb.sv @@
// Testbench for radix_number_literal_scanner_core: directed and random byte streams,
// a scoreboard class predicting each closed literal, random gaps and stalls on both sides.
// Depends on rnls_pkg, rnls_if and the scanner RTL.
`timescale 1ns / 1ps

module radix_number_literal_scanner_core_tb;
    import rnls_pkg::*;

    localparam int ITEM_TARGET = 650;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        radix_t             radix;
    } literal_t;

    class literal_tracker;
        localparam logic [VALUE_W-1:0] DEC_BASE = 64'd10;
        localparam logic [3:0]         HEX_TEN  = 4'hA;

        mode_t              mode;
        logic [VALUE_W-1:0] acc;
        literal_t           pending_literals[$];
        int                 errors;

        function new();
            mode   = MODE_IDLE;
            acc    = '0;
            errors = 0;
        endfunction

        task report(string what);
            $display("mismatch @%0t: %s", $realtime, what);
            errors++;
        endtask

        function radix_t radix_for(mode_t m);
            case (m)
                MODE_BIN: return RADIX_BIN;
                MODE_OCT: return RADIX_OCT;
                MODE_HEX: return RADIX_HEX;
                default:  return RADIX_DEC;
            endcase
        endfunction

        function void emit(logic [VALUE_W-1:0] v, radix_t r);
            literal_t lit;
            lit.value = v;
            lit.radix = r;
            pending_literals = {pending_literals, lit};
        endfunction

        function void open_literal(logic [TEXT_W-1:0] c);
            if (c == CH_0)
            begin
                mode = MODE_ZERO;
                acc  = '0;
            end
            else if (c >= CH_1 && c <= CH_9)
            begin
                mode = MODE_DEC;
                acc  = VALUE_W'(c - CH_0);
            end
            else
            begin
                mode = MODE_IDLE;
                acc  = '0;
            end
        endfunction

        // true when c extends the open literal
        function bit add_digit(logic [TEXT_W-1:0] c);
            case (mode)
                MODE_DEC:
                begin
                    if (c < CH_0 || c > CH_9)
                        return 0;
                    acc = acc * DEC_BASE + VALUE_W'(c - CH_0);
                    return 1;
                end
                MODE_BIN:
                begin
                    if (c != CH_0 && c != CH_1)
                        return 0;
                    acc = {acc[VALUE_W-2:0], c[0]};
                    return 1;
                end
                MODE_OCT:
                begin
                    if (c < CH_0 || c > CH_7)
                        return 0;
                    acc = {acc[VALUE_W-4:0], c[2:0]};
                    return 1;
                end
                MODE_HEX:
                begin
                    if (c >= CH_0 && c <= CH_9)
                        acc = {acc[VALUE_W-5:0], c[3:0]};
                    else if (c >= CH_LO_A && c <= CH_LO_F)
                        acc = {acc[VALUE_W-5:0], 4'(c - CH_LO_A) + HEX_TEN};
                    else if (c >= CH_UP_A && c <= CH_UP_F)
                        acc = {acc[VALUE_W-5:0], 4'(c - CH_UP_A) + HEX_TEN};
                    else
                        return 0;
                    return 1;
                end
                default: return 0;
            endcase
        endfunction

        function void take_byte(logic [TEXT_W-1:0] c, logic end_mark);
            if (end_mark)
            begin
                if (mode != MODE_IDLE)
                    emit((mode == MODE_ZERO) ? '0 : acc, radix_for(mode));
                mode = MODE_IDLE;
                acc  = '0;
                return;
            end
            case (mode)
                MODE_IDLE: open_literal(c);
                MODE_ZERO:
                begin
                    acc = '0;
                    if (c == CH_LO_B || c == CH_UP_B)
                        mode = MODE_BIN;
                    else if (c == CH_LO_O || c == CH_UP_O)
                        mode = MODE_OCT;
                    else if (c == CH_LO_X || c == CH_UP_X)
                        mode = MODE_HEX;
                    else
                    begin
                        emit('0, RADIX_DEC);
                        open_literal(c);
                    end
                end
                default:
                begin
                    if (!add_digit(c))
                    begin
                        emit(acc, radix_for(mode));
                        open_literal(c);
                    end
                end
            endcase
        endfunction

        task check_literal(logic [VALUE_W-1:0] v, logic [RADIX_W-1:0] r);
            literal_t exp_lit;
            if (pending_literals.size() == 0)
            begin
                report($sformatf("unexpected literal value=%0h radix=%0d", v, r));
                return;
            end
            exp_lit = pending_literals.pop_front();
            if (v !== exp_lit.value)
                report($sformatf("literal_value %0h, want %0h", v, exp_lit.value));
            if (r !== exp_lit.radix)
                report($sformatf("literal_radix %0d, want %0d", r, exp_lit.radix));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    int   beats_sent;
    bit   send_steady;
    bit   recv_steady;
    int   stall_left;

    literal_tracker tracker = new();

    rnls_text_if text_ch ();
    rnls_lit_if  lit_ch ();

    radix_number_literal_scanner_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_ch.sink),
        .lit_out (lit_ch.source)
    );

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        text_ch.valid      = 1'b0;
        text_ch.text_byte  = '0;
        text_ch.end_mark   = 1'b0;
        lit_ch.ready       = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[radix_number_literal_scanner_core] ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        else if (r < 95)
            return $urandom_range(3, 6);
        return $urandom_range(10, 40);
    endfunction

    always @(negedge clk)
    begin
        if (cycles % 256 == 0)
            recv_steady = ($urandom_range(0, 2) == 0);
        if (stall_left != 0)
        begin
            lit_ch.ready <= 1'b0;
            stall_left--;
        end
        else if (!recv_steady && $urandom_range(0, 3) == 0)
        begin
            lit_ch.ready <= 1'b0;
            stall_left = pick_gap() - 1;
        end
        else
            lit_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && lit_ch.valid && lit_ch.ready)
            tracker.check_literal(lit_ch.literal_value, lit_ch.literal_radix);
    end

    task idle_gap();
        int n;
        if (send_steady || $urandom_range(0, 1) == 0)
            return;
        n = pick_gap();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task push_byte(logic [TEXT_W-1:0] c, logic e);
        @(negedge clk);
        text_ch.valid     <= 1'b1;
        text_ch.text_byte <= c;
        text_ch.end_mark  <= e;
        do
            @(posedge clk);
        while (!text_ch.ready);
        tracker.take_byte(c, e);
        beats_sent++;
        idle_gap();
    endtask

    task push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    task push_end();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task wait_drained();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (tracker.pending_literals.size() != 0)
            @(posedge clk);
    endtask

    function logic [TEXT_W-1:0] digit_for(mode_t m);
        int r;
        case (m)
            MODE_BIN: return 8'(CH_0 + $urandom_range(0, 1));
            MODE_OCT: return 8'(CH_0 + $urandom_range(0, 7));
            MODE_HEX:
            begin
                r = $urandom_range(0, 21);
                if (r < 10)
                    return 8'(CH_0 + r);
                else if (r < 16)
                    return 8'(CH_LO_A + r - 10);
                return 8'(CH_UP_A + r - 16);
            end
            default: return 8'(CH_0 + $urandom_range(0, 9));
        endcase
    endfunction

    task push_literal();
        int    kind;
        int    n;
        bit    long_run;
        mode_t m;
        kind     = $urandom_range(0, 9);
        long_run = ($urandom_range(0, 9) == 0);
        n        = $urandom_range(0, 5);
        if (kind >= 8)
        begin
            push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
            return;
        end
        if (kind == 7)
        begin
            push_byte(CH_0, 1'b0);
        end
        else if (kind <= 2)
        begin
            m = MODE_DEC;
            if (long_run)
                n = $urandom_range(15, 25);
            push_byte(8'(CH_1 + $urandom_range(0, 8)), 1'b0);
        end
        else
        begin
            push_byte(CH_0, 1'b0);
            case (kind)
                3:
                begin
                    m = MODE_BIN;
                    if (long_run)
                        n = $urandom_range(60, 70);
                    push_byte($urandom_range(0, 1) ? CH_LO_B : CH_UP_B, 1'b0);
                end
                4:
                begin
                    m = MODE_OCT;
                    if (long_run)
                        n = $urandom_range(20, 24);
                    push_byte($urandom_range(0, 1) ? CH_LO_O : CH_UP_O, 1'b0);
                end
                default:
                begin
                    m = MODE_HEX;
                    if (long_run)
                        n = $urandom_range(15, 18);
                    push_byte($urandom_range(0, 1) ? CH_LO_X : CH_UP_X, 1'b0);
                end
            endcase
        end
        if (kind != 7)
            repeat (n) push_byte(digit_for(m), 1'b0);
        case ($urandom_range(0, 5))
            0, 1: push_end();
            2: ;
            default: push_byte(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endtask

    initial
    begin
        bit paused;
        cycles      = 0;
        beats_sent  = 0;
        stall_left  = 0;
        recv_steady = 1'b0;
        send_steady = 1'b0;
        paused      = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // end while idle, lone zero, prefixes of both cases, a digit that closes and reopens
        push_end();
        push_text("9a0q0b12");
        push_end();
        push_text("0XfF");
        push_byte(8'hFF, 1'b0);
        push_text("0o78 0B0O");
        push_byte(8'h00, 1'b0);
        push_end();

        wait_drained();

        while (beats_sent < ITEM_TARGET)
        begin
            send_steady = ($urandom_range(0, 4) == 0);
            push_literal();
            if (!paused && beats_sent > ITEM_TARGET / 2)
            begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_literals.size() != 0)
            tracker.report($sformatf("%0d literals never arrived",
                                     tracker.pending_literals.size()));
        if (tracker.errors == 0)
            $display("[radix_number_literal_scanner_core] OK");
        else
            $display("[radix_number_literal_scanner_core] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/rnls_pkg.sv
design/rnls_if.sv
design/radix_number_literal_scanner_core.sv
tb/sv/radix_number_literal_scanner_core_tb.sv
